[src/spl_pkg.sv]
package spl_pkg;

	// Store geometry: header, payload and the two checksum bytes.
	localparam int MAX_PAYLOAD = 254;
	localparam int STORE_SIZE  = MAX_PAYLOAD + 6;
	localparam int IDX_W       = 9;
	localparam logic [IDX_W-1:0] STORE_TOP = IDX_W'(STORE_SIZE - 1);

	// Link bytes.
	localparam logic [7:0] SYNC_A       = 8'h99;
	localparam logic [7:0] SYNC_B       = 8'h66;
	localparam logic [7:0] ACK_FLIP     = 8'h80;
	localparam logic [7:0] FILLER       = 8'hD2;
	localparam logic [7:0] ERR_UNKNOWN  = 8'hF0;
	localparam logic [7:0] ERR_CHECKSUM = 8'hF1;
	localparam logic [7:0] NULL_BYTE    = 8'h00;

	// Word commands.
	localparam logic [1:0] CMD_EXCHANGE = 2'd0;
	localparam logic [1:0] CMD_WRITE    = 2'd1;
	localparam logic [1:0] CMD_READ     = 2'd2;
	localparam logic [1:0] CMD_REPLY    = 2'd3;

	// Protocol phases.
	localparam logic [2:0] PH_SYNC     = 3'd0;
	localparam logic [2:0] PH_BODY     = 3'd1;
	localparam logic [2:0] PH_CSUM     = 3'd2;
	localparam logic [2:0] PH_ACK      = 3'd3;
	localparam logic [2:0] PH_WAIT     = 3'd4;
	localparam logic [2:0] PH_TX_SYNC  = 3'd5;
	localparam logic [2:0] PH_TX_DATA  = 3'd6;
	localparam logic [2:0] PH_TX_ACK   = 3'd7;

	localparam logic [2:0] RETRY_MAX   = 3'd7;
	localparam logic [2:0] RETRY_LIMIT = 3'd4;

	// Configuration register select (address bit 2).
	localparam logic REG_ADAPTER_ID  = 1'b0;
	localparam logic REG_SESSION_CMD = 1'b1;

endpackage

[src/spl_ifs.sv]
interface spl_req_if import spl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       command;
	logic [7:0]       link_byte;
	logic [IDX_W-1:0] store_index;
	logic             session_open;

	modport source (output valid, command, link_byte, store_index, session_open, input ready);
	modport sink   (input valid, command, link_byte, store_index, session_open, output ready);
endinterface

interface spl_rsp_if import spl_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] reply_byte;
	logic [7:0] read_data;
	logic       packet_ready;
	logic [2:0] phase_now;

	modport source (output valid, reply_byte, read_data, packet_ready, phase_now, input ready);
	modport sink   (input valid, reply_byte, read_data, packet_ready, phase_now, output ready);
endinterface

[src/serial_packet_link_responder_core.sv]
// Slave side of a byte-exchange serial link.
// Words enter on req (valid/ready). An exchange word carries the byte from the
// master and yields the byte to send back; write, read and reply-start words
// reach the packet store and the reply sequencer directly. Each word gives
// exactly one result word on rsp, in order.
// A word is taken into an input register, worked on from there once the result
// register is free and placed in the result register. One word is accepted
// every cycle while the receiver takes the results: the state update and the one
// store access per word are done together, with the store read fetched ahead
// into a register from the state the previous word leaves.
// When the receiver stalls, the result register holds, the input register
// fills and req.ready then falls until rsp moves again; nothing is dropped.
// The APB port writes adapter_id (0x0) and session_start_cmd (0x4); the user must
// write them only while the block is idle, which the block does not enforce. pready
// is always high and reads return the registers. Reset clears the phase, counters,
// handshake state and restores the register defaults. The packet store is not cleared:
// entries are undefined until written, so the block is ready right after reset.
module serial_packet_link_responder_core import spl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	spl_req_if.sink     req,
	spl_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers.
	logic [7:0] adapter_id_q;
	logic [7:0] session_cmd_q;

	// Input register.
	logic             valid_s1;
	logic [1:0]       cmd_s1;
	logic [7:0]       byte_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             sess_s1;

	// Protocol state.
	logic [2:0]       phase_q;
	logic [IDX_W-1:0] pos_q;
	logic [7:0]       len_q;
	logic [15:0]      sum_q;
	logic             sum_err_q;
	logic [2:0]       retry_q;

	// Packet store, plus copies of the command and length entries that the
	// protocol consults at fixed places.
	logic [7:0]       store_mem [STORE_SIZE];
	logic [7:0]       st0_q;
	logic [7:0]       st3_q;
	logic [7:0]       rd_mem_q;
	logic             rd_zero_q;
	logic             rd_byp_sel_q;
	logic [7:0]       rd_byp_q;
	logic [7:0]       rd_val;

	// Result register.
	logic       out_valid_q;
	logic [7:0] reply_q;
	logic [7:0] rdata_q;
	logic       ready_q;
	logic [2:0] phase_out_q;

	// Next-state logic.
	logic             fire;
	logic [2:0]       phase_n;
	logic [IDX_W-1:0] pos_n;
	logic [IDX_W-1:0] pos_inc;
	logic [7:0]       len_n;
	logic [15:0]      sum_n;
	logic             err_n;
	logic [2:0]       retry_n;
	logic [2:0]       retry_up;
	logic [7:0]       reply_c;
	logic [7:0]       rdata_c;
	logic             ready_c;
	logic             we_c;
	logic [IDX_W-1:0] waddr_c;
	logic [7:0]       hi_c;
	logic [9:0]       len_ext;

	// Read prefetch.
	logic [1:0]       nxt_cmd;
	logic [IDX_W-1:0] nxt_idx;
	logic [2:0]       ph_eff;
	logic [IDX_W-1:0] pos_eff;
	logic [IDX_W-1:0] raddr;
	logic             rzero;
	logic [IDX_W-1:0] raddr_ix;
	logic             wr_ok;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SESSION_CMD) ? {24'b0, session_cmd_q}
	                                               : {24'b0, adapter_id_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adapter_id_q  <= 8'd136;
			session_cmd_q <= 8'd16;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_SESSION_CMD) begin
				session_cmd_q <= pwdata[7:0];
			end else begin
				adapter_id_q <= pwdata[7:0];
			end
		end
	end

	// ---------------------------------------------------------- handshake
	// The word in the input register is worked on when the result register
	// is free or being emptied in this cycle.
	assign fire      = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.command;
			byte_s1 <= req.link_byte;
			idx_s1  <= req.store_index;
			sess_s1 <= req.session_open;
		end
	end

	// --------------------------------------------------------- store read
	// The read data was fetched last cycle for exactly this word and state;
	// a write landing on the same entry in that cycle was forwarded.
	assign rd_val = rd_byp_sel_q ? rd_byp_q : (rd_zero_q ? NULL_BYTE : rd_mem_q);

	// ------------------------------------------------------ word processing
	assign pos_inc = pos_q + 1'b1;
	assign len_ext = {2'b00, len_q};
	assign retry_up = (retry_q < RETRY_MAX) ? retry_q + 1'b1 : retry_q;

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		len_n   = len_q;
		sum_n   = sum_q;
		err_n   = sum_err_q;
		retry_n = retry_q;
		reply_c = FILLER;
		rdata_c = NULL_BYTE;
		ready_c = 1'b0;
		we_c    = 1'b0;
		waddr_c = idx_s1;
		hi_c    = NULL_BYTE;
		unique case (cmd_s1)
			CMD_EXCHANGE: begin
				unique case (phase_q)
					PH_SYNC: begin
						if (byte_s1 == SYNC_A) begin
							pos_n = IDX_W'(1);
						end else if (byte_s1 == SYNC_B && pos_q == IDX_W'(1)) begin
							pos_n   = '0;
							len_n   = 8'd0;
							sum_n   = 16'd0;
							err_n   = 1'b0;
							phase_n = PH_BODY;
						end else begin
							pos_n = '0;
						end
					end
					PH_BODY: begin
						we_c    = 1'b1;
						waddr_c = pos_q;
						pos_n   = pos_inc;
						sum_n   = sum_q + {8'd0, byte_s1};
						if (pos_inc == IDX_W'(4)) begin
							// Header complete: the length is the byte just taken.
							len_n = byte_s1;
							if (!sess_s1 && st0_q != session_cmd_q) begin
								pos_n   = '0;
								phase_n = PH_SYNC;
							end else if (byte_s1 == 8'd0) begin
								phase_n = PH_CSUM;
							end
						end else if ({1'b0, pos_inc} >= len_ext + 10'd4) begin
							phase_n = PH_CSUM;
						end
					end
					PH_CSUM: begin
						we_c    = 1'b1;
						waddr_c = pos_q;
						pos_n   = pos_inc;
						if ({1'b0, pos_inc} >= len_ext + 10'd6) begin
							// High checksum byte is the entry written one word ago.
							hi_c    = (pos_inc >= IDX_W'(2)) ? rd_val : NULL_BYTE;
							if ({hi_c, byte_s1} != sum_q) begin
								err_n = 1'b1;
							end
							phase_n = PH_ACK;
							reply_c = adapter_id_q;
						end
					end
					PH_ACK: begin
						pos_n   = '0;
						phase_n = PH_SYNC;
						if (sum_err_q) begin
							reply_c = ERR_CHECKSUM;
						end else if (byte_s1 != ACK_FLIP) begin
							reply_c = ERR_UNKNOWN;
						end else begin
							retry_n = 3'd0;
							phase_n = PH_WAIT;
							ready_c = 1'b1;
							reply_c = st0_q ^ ACK_FLIP;
						end
					end
					PH_WAIT: begin
						reply_c = FILLER;
					end
					PH_TX_SYNC: begin
						if (pos_q == '0) begin
							pos_n   = IDX_W'(1);
							reply_c = SYNC_A;
						end else begin
							len_n   = st3_q;
							pos_n   = '0;
							phase_n = PH_TX_DATA;
							reply_c = SYNC_B;
						end
					end
					PH_TX_DATA: begin
						if ({1'b0, pos_inc} > len_ext + 10'd6) begin
							pos_n   = '0;
							phase_n = PH_TX_ACK;
							reply_c = adapter_id_q;
						end else begin
							pos_n   = pos_inc;
							reply_c = rd_val;
						end
					end
					PH_TX_ACK: begin
						if (pos_q == '0) begin
							pos_n   = IDX_W'(1);
							reply_c = NULL_BYTE;
						end else if ((byte_s1 ^ ACK_FLIP) != st0_q) begin
							// Not acknowledged: resend while retries remain.
							retry_n = retry_up;
							if (retry_up < RETRY_LIMIT) begin
								pos_n   = IDX_W'(1);
								phase_n = PH_TX_SYNC;
								reply_c = SYNC_A;
							end else begin
								pos_n   = '0;
								phase_n = PH_SYNC;
							end
						end else begin
							pos_n   = '0;
							phase_n = PH_SYNC;
						end
					end
				endcase
			end
			CMD_WRITE: begin
				we_c    = 1'b1;
				waddr_c = idx_s1;
			end
			CMD_READ: begin
				rdata_c = rd_val;
			end
			CMD_REPLY: begin
				phase_n = PH_TX_SYNC;
				pos_n   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC;
			pos_q     <= '0;
			len_q     <= 8'd0;
			sum_q     <= 16'd0;
			sum_err_q <= 1'b0;
			retry_q   <= 3'd0;
		end else if (fire) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			len_q     <= len_n;
			sum_q     <= sum_n;
			sum_err_q <= err_n;
			retry_q   <= retry_n;
		end
	end

	// -------------------------------------------------------- store write
	// Writes beyond the end of the store are dropped.
	assign wr_ok = fire && we_c && (waddr_c <= STORE_TOP);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			store_mem[waddr_c] <= byte_s1;
			if (waddr_c == IDX_W'(0)) begin
				st0_q <= byte_s1;
			end
			if (waddr_c == IDX_W'(3)) begin
				st3_q <= byte_s1;
			end
		end
	end

	// ----------------------------------------------------- read prefetch
	// Address for the word that sits in the input register next cycle,
	// taken from the state it will see.
	assign nxt_cmd = (req.valid && req.ready) ? req.command : cmd_s1;
	assign nxt_idx = (req.valid && req.ready) ? req.store_index : idx_s1;
	assign ph_eff  = fire ? phase_n : phase_q;
	assign pos_eff = fire ? pos_n : pos_q;

	always_comb begin
		rzero = 1'b0;
		if (nxt_cmd == CMD_READ) begin
			raddr = nxt_idx;
		end else if (ph_eff == PH_CSUM) begin
			raddr = pos_eff - 1'b1;
			rzero = (pos_eff == '0);
		end else begin
			raddr = pos_eff;
		end
		if (raddr > STORE_TOP) begin
			rzero = 1'b1;
		end
		raddr_ix = rzero ? '0 : raddr;
	end

	always_ff @(posedge clk) begin
		rd_mem_q     <= store_mem[raddr_ix];
		rd_zero_q    <= rzero;
		rd_byp_sel_q <= wr_ok && !rzero && (waddr_c == raddr);
		rd_byp_q     <= byte_s1;
	end

	// ---------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			reply_q     <= reply_c;
			rdata_q     <= rdata_c;
			ready_q     <= ready_c;
			phase_out_q <= phase_n;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.reply_byte   = reply_q;
	assign rsp.read_data    = rdata_q;
	assign rsp.packet_ready = ready_q;
	assign rsp.phase_now    = phase_out_q;

`ifndef NO_ASSERTIONS
	// A word in the input register is never lost while it waits.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1)
		else $error("input register word dropped while stalled");

	// A clean acknowledge always leaves the block waiting for a reply start.
	a_ready_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.packet_ready |-> rsp.phase_now == PH_WAIT)
		else $error("packet_ready outside the reply wait phase");

	// Only a read word carries store data, and it sends the filler byte.
	a_read_filler: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.read_data != NULL_BYTE |-> rsp.reply_byte == FILLER)
		else $error("read data on a word that is not a store read");

	// A reply start lands in the reply sync phase at its first position.
	a_reply_start: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_s1 == CMD_REPLY |=> phase_q == PH_TX_SYNC && pos_q == '0)
		else $error("reply start did not reset the reply sequencer");
`endif

endmodule
